>>> rtl/qcs_pkg.sv
// Shared types and constants for the quorum completion scoreboard.
package qcs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int PROC_W    = 4;
  localparam int SEQ_BITS  = 48;
  localparam int KIND_BITS = 4;
  localparam int QUORUM_W  = 5;
  localparam int STRIDE_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Result codes
  typedef enum logic [3:0] {
    OC_COUNTED      = 4'd0,
    OC_TRACKED      = 4'd1,
    OC_BROKEN       = 4'd2,
    OC_IGNORED      = 4'd3,
    OC_BROADCAST    = 4'd4,
    OC_FAILED       = 4'd5,
    OC_RESTARTED    = 4'd6,
    OC_ZERO_RESTART = 4'd7,
    OC_NOT_STARTED  = 4'd8
  } outcome_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUORUM_SIZE  = 3'd0,
    CFG_STRIDE       = 3'd1,
    CFG_OWN_KIND     = 3'd2,
    CFG_BCAST_KIND   = 3'd3,
    CFG_BCAST_ENABLE = 3'd4
  } cfg_reg_t;

  // Request opcode
  typedef enum logic {
    OP_ENTRY   = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef struct packed {
    logic                 op;
    logic                 completion_ok;
    logic [KIND_BITS-1:0] entry_kind;
    logic [PROC_W-1:0]    proc_id;
    logic [SEQ_BITS-1:0]  seq_number;
  } qcs_in_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [PROC_W-1:0]    proc_id_out;
    logic [QUORUM_W-1:0]  remaining;
    logic                 round_advanced;
    logic [SEQ_BITS-1:0]  round_id_out;
  } qcs_out_t;

  // Input stage to core
  typedef struct packed {
    logic    valid;
    qcs_in_t data;
  } qcs_req_t;

endpackage

>>> rtl/qcs_in_stage.sv
// Input register stage of the scoreboard.
module qcs_in_stage
  import qcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qcs_in_t  in_data,
  input  logic     advance,
  output qcs_req_t req
);

  logic    in_valid_r;
  qcs_in_t in_data_r;

  // Holding a request that the core cannot take yet
  assign in_stall = in_valid_r && !advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  assign req.valid = in_valid_r;
  assign req.data  = in_data_r;

endmodule

>>> rtl/qcs_core.sv
// Scoreboard state, update logic, configuration and result register.
module qcs_core
  import qcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  qcs_req_t              req,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qcs_out_t              out_data
);

  // Configuration
  logic [QUORUM_W-1:0]  quorum_r;
  logic [STRIDE_W-1:0]  stride_r;
  logic [KIND_BITS-1:0] own_kind_r;
  logic [KIND_BITS-1:0] bcast_kind_r;
  logic                 bcast_en_r;

  // Scoreboard state: per-process entries fall back to a common fill value
  // until written after the last fill.
  logic [SEQ_BITS-1:0]  seq_arr_r   [MAX_PROCS];
  logic [MAX_PROCS-1:0] entry_vld_r, entry_vld_nxt;
  logic [SEQ_BITS-1:0]  fill_val_r, fill_val_nxt;
  logic [SEQ_BITS-1:0]  round_r, round_nxt;
  logic [QUORUM_W-1:0]  count_r, count_nxt;
  logic                 started_r, started_nxt;

  logic                 out_valid_r;
  qcs_out_t             out_data_r, out_data_nxt;

  logic                 fire;
  logic                 arr_we;
  logic [SEQ_BITS-1:0]  arr_wdata;
  logic [SEQ_BITS-1:0]  stride_ext;
  logic [QUORUM_W-1:0]  eff_quorum;
  logic [SEQ_BITS-1:0]  cur_seq;
  logic                 chained;
  logic [SEQ_BITS-1:0]  stored;
  logic                 pid_ok;
  logic                 advanced;
  outcome_t             outcome;
  qcs_in_t              d;

  assign advance    = !out_valid_r || !out_stall;
  assign fire       = req.valid && advance;
  assign d          = req.data;
  assign stride_ext = {{(SEQ_BITS-STRIDE_W){1'b0}}, stride_r};
  assign eff_quorum = (quorum_r == '0) ? QUORUM_W'(1) : quorum_r;
  assign pid_ok     = (32'(d.proc_id) < MAX_PROCS);
  assign cur_seq    = entry_vld_r[d.proc_id] ? seq_arr_r[d.proc_id] : fill_val_r;
  assign chained    = ((cur_seq + stride_ext) == d.seq_number);
  assign stored     = chained ? d.seq_number : '0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quorum_r     <= QUORUM_W'(1);
      stride_r     <= STRIDE_W'(1);
      own_kind_r   <= '0;
      bcast_kind_r <= KIND_BITS'(1);
      bcast_en_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_QUORUM_SIZE:  quorum_r     <= cfg_wdata[QUORUM_W-1:0];
        CFG_STRIDE:       stride_r     <= cfg_wdata[STRIDE_W-1:0];
        CFG_OWN_KIND:     own_kind_r   <= cfg_wdata[KIND_BITS-1:0];
        CFG_BCAST_KIND:   bcast_kind_r <= cfg_wdata[KIND_BITS-1:0];
        CFG_BCAST_ENABLE: bcast_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next-state and result for the request in the input register
  always_comb begin
    entry_vld_nxt = entry_vld_r;
    fill_val_nxt  = fill_val_r;
    round_nxt     = round_r;
    count_nxt     = count_r;
    started_nxt   = started_r;
    arr_we        = 1'b0;
    arr_wdata     = stored;
    advanced      = 1'b0;
    outcome       = OC_IGNORED;
    if (d.op == OP_RESTART) begin
      if (d.seq_number == '0) begin
        outcome = OC_ZERO_RESTART;
      end else begin
        entry_vld_nxt = '0;
        fill_val_nxt  = d.seq_number - stride_ext;
        count_nxt     = eff_quorum;
        round_nxt     = d.seq_number;
        started_nxt   = 1'b1;
        outcome       = OC_RESTARTED;
      end
    end else if (!started_r) begin
      outcome = OC_NOT_STARTED;
    end else if (!d.completion_ok) begin
      outcome = OC_FAILED;
    end else if (d.entry_kind != own_kind_r) begin
      if (bcast_en_r && (d.entry_kind == bcast_kind_r)) begin
        entry_vld_nxt = '0;
        fill_val_nxt  = round_r;
        round_nxt     = round_r + stride_ext;
        count_nxt     = eff_quorum;
        advanced      = 1'b1;
        outcome       = OC_BROADCAST;
      end
    end else if (pid_ok) begin
      arr_we                 = 1'b1;
      entry_vld_nxt[d.proc_id] = 1'b1;
      if (stored == round_r) begin
        outcome = OC_COUNTED;
        if (count_r <= QUORUM_W'(1)) begin
          count_nxt = eff_quorum;
          round_nxt = round_r + stride_ext;
          advanced  = 1'b1;
        end else begin
          count_nxt = count_r - QUORUM_W'(1);
        end
      end else begin
        outcome = chained ? OC_TRACKED : OC_BROKEN;
      end
    end
    out_data_nxt.outcome        = outcome;
    out_data_nxt.proc_id_out    = d.proc_id;
    out_data_nxt.remaining      = count_nxt;
    out_data_nxt.round_advanced = advanced;
    out_data_nxt.round_id_out   = round_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      fill_val_r  <= '0;
      round_r     <= '0;
      count_r     <= '0;
      started_r   <= 1'b0;
    end else if (fire) begin
      entry_vld_r <= entry_vld_nxt;
      fill_val_r  <= fill_val_nxt;
      round_r     <= round_nxt;
      count_r     <= count_nxt;
      started_r   <= started_nxt;
    end
  end

  // Per-process entries
  always_ff @(posedge clk) begin
    if (fire && arr_we) begin
      seq_arr_r[d.proc_id] <= arr_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/quorum_completion_scoreboard.sv
// Top level of the quorum completion scoreboard.
//
//  Channel  Direction  Handshake               Payload
//  in_      input      in_valid / in_stall     qcs_in_t   (one request)
//  out_     output     out_valid / out_stall   qcs_out_t  (one result per request)
//  cfg_     input      cfg_wr_en               cfg_index, cfg_wdata
//
// The result passes through the input register and then the result register; one
// request per cycle is sustained while out_stall is low, as the core updates its state for every request it takes.
// Synchronous active-low reset clears the scoreboard; fills on restart and
// broadcast take effect at once through per-process valid bits.
// An output stall holds the result register and then the input register.
module quorum_completion_scoreboard
  import qcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  qcs_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qcs_out_t              out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  qcs_req_t req;
  logic     advance;

  qcs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .req      (req)
  );

  qcs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/qcs_checker.sv
// Port-level checks for the quorum completion scoreboard, bound to the top.
module qcs_checker
  import qcs_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input qcs_out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only a counted entry or a broadcast moves the round
  a_adv_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.round_advanced |->
      (out_data.outcome == OC_COUNTED || out_data.outcome == OC_BROADCAST))
    else $error("round advanced on wrong outcome");

  // Before any restart the scoreboard is still cleared
  a_not_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OC_NOT_STARTED |->
      out_data.remaining == '0 && out_data.round_id_out == '0)
    else $error("state changed before restart");

  // A restart loads a nonzero round and a nonzero count
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OC_RESTARTED |->
      out_data.remaining != '0 && out_data.round_id_out != '0 && !out_data.round_advanced)
    else $error("restart result inconsistent");

endmodule

bind quorum_completion_scoreboard qcs_checker u_qcs_checker (.*);
